// File: hdl/tsst_pkg.sv
// ----------------------------------------------------------------------------
// tsst_pkg
// Shared types and constants for the per-symbol trade statistics table.
// ----------------------------------------------------------------------------
`default_nettype none

package tsst_pkg;

    localparam int NUM_SYMBOLS_DEF = 64;
    localparam int TICKER_W = 24;
    localparam int TIME_W   = 64;
    localparam int SUM_W    = 64;
    localparam int WORD_W   = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_WAIT,
        S_MUL,
        S_ACC,
        S_DIVGO,
        S_DIV,
        S_WR,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, clear scan
        logic scan;      // step key search by one entry
        logic rd;        // issue stats read
        logic mul;       // register product and gap
        logic acc;       // register updated stats
        logic div_start; // start average divider
        logic wr;        // write back entry
        logic done;      // present result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // scan finished this cycle
        logic div_done;
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/trade_symbol_stats_table_top.sv
// ----------------------------------------------------------------------------
// trade_symbol_stats_table_top
// Per-symbol trade statistics with volume weighted average price.
//
// channel   direction  handshake            fields
// trade     in         start / busy         trade_time ticker quantity price
// stats     out        o_valid strobe       ticker_out largest_gap total_volume
//                                           average_price top_price table_full
//
// The key scan reads one table entry per cycle, then a bit-serial divider
// forms the average price. busy stays high from acceptance until the result
// strobe. Synchronous reset clears the entry-used flags; no clearing pass is
// needed. o_valid is high for a single cycle; the result fields hold until
// the next result. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module trade_symbol_stats_table_top
    import tsst_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire logic [TIME_W-1:0]   i_trade_time,
    input  wire logic [TICKER_W-1:0] i_ticker,
    input  wire logic [WORD_W-1:0]   i_quantity,
    input  wire logic [WORD_W-1:0]   i_price,
    output      logic                o_valid,
    output      logic [TICKER_W-1:0] o_ticker_out,
    output      logic [TIME_W-1:0]   o_largest_gap,
    output      logic [SUM_W-1:0]    o_total_volume,
    output      logic [WORD_W-1:0]   o_average_price,
    output      logic [WORD_W-1:0]   o_top_price,
    output      logic                o_table_full
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tsst_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    tsst_dp #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_trade_time(i_trade_time), .i_ticker(i_ticker),
        .i_quantity(i_quantity), .i_price(i_price),
        .o_valid(o_valid), .o_ticker_out(o_ticker_out),
        .o_largest_gap(o_largest_gap), .o_total_volume(o_total_volume),
        .o_average_price(o_average_price), .o_top_price(o_top_price),
        .o_table_full(o_table_full)
    );

endmodule

`default_nettype wire

// File: hdl/tsst_ram.sv
// ----------------------------------------------------------------------------
// tsst_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/tsst_div.sv
// ----------------------------------------------------------------------------
// tsst_div
// Radix-2 restoring divider, 64 by 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_div
    import tsst_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_num,
    input  wire logic [SUM_W-1:0] i_den,
    output      logic             o_done,
    output      logic [SUM_W-1:0] o_quo
);

    logic [SUM_W-1:0]         r_quo, n_quo;
    logic [SUM_W-1:0]         r_rem, n_rem;
    logic [SUM_W-1:0]         r_den;
    logic [$clog2(SUM_W):0]   r_cnt;
    logic                     r_busy;
    logic [SUM_W:0]           w_shift;
    logic [SUM_W:0]           w_diff;

    // one restoring step
    always_comb begin
        w_shift = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        n_quo   = {r_quo[SUM_W-2:0], ~w_diff[SUM_W]};
        n_rem   = w_diff[SUM_W] ? w_shift[SUM_W-1:0] : w_diff[SUM_W-1:0];
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(SUM_W)+1)'(SUM_W-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

// File: hdl/tsst_ctrl.sv
// ----------------------------------------------------------------------------
// tsst_ctrl
// Sequencer for one trade: key scan, read, update, divide, write back.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_ctrl
    import tsst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output      logic  busy,
    input  wire t_stat i_stat,
    output      t_cmd  o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_SCAN;
            S_SCAN:  if (i_stat.scan_last) n_state = S_RD;
            S_RD:    n_state = S_WAIT;
            S_WAIT:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (i_stat.div_done) n_state = S_WR;
            S_WR:    n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:  o_cmd.load = start;
            S_SCAN:  o_cmd.scan = 1'b1;
            S_RD:    o_cmd.rd   = 1'b1;
            S_WAIT:  ;
            S_MUL:   o_cmd.mul  = 1'b1;
            S_ACC:   o_cmd.acc  = 1'b1;
            S_DIVGO: o_cmd.div_start = 1'b1;
            S_DIV:   ;
            S_WR:    o_cmd.wr   = 1'b1;
            S_DONE:  o_cmd.done = 1'b1;
            default: ;
        endcase
    end

    // sequencing checks
    property p_scan_then_rd;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_SCAN && i_stat.scan_last) |=> (r_state == S_RD);
    endproperty
    a_scan_then_rd: assert property (p_scan_then_rd) else $error("scan exit");

    property p_div_exit;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DIV && i_stat.div_done) |=> (r_state == S_WR);
    endproperty
    a_div_exit: assert property (p_div_exit) else $error("divider exit");

    property p_done_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DONE) |=> !busy;
    endproperty
    a_done_idle: assert property (p_done_idle) else $error("done not idle");

endmodule

`default_nettype wire

// File: hdl/tsst_dp.sv
// ----------------------------------------------------------------------------
// tsst_dp
// Datapath: key table scan, statistics memories, update and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsst_dp
    import tsst_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output      t_stat               o_stat,
    input  wire logic [TIME_W-1:0]   i_trade_time,
    input  wire logic [TICKER_W-1:0] i_ticker,
    input  wire logic [WORD_W-1:0]   i_quantity,
    input  wire logic [WORD_W-1:0]   i_price,
    output      logic                o_valid,
    output      logic [TICKER_W-1:0] o_ticker_out,
    output      logic [TIME_W-1:0]   o_largest_gap,
    output      logic [SUM_W-1:0]    o_total_volume,
    output      logic [WORD_W-1:0]   o_average_price,
    output      logic [WORD_W-1:0]   o_top_price,
    output      logic                o_table_full
);

    localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CW = $clog2(NUM_SYMBOLS + 1);

    // captured item
    logic [TIME_W-1:0]   r_time;
    logic [TICKER_W-1:0] r_key;
    logic [WORD_W-1:0]   r_qty, r_price;

    // scan state
    logic [CW-1:0] r_idx;
    logic          r_hit, r_free_found, r_new;
    logic [AW-1:0] r_sel, r_free;
    logic [NUM_SYMBOLS-1:0] r_used;

    // update registers
    logic [SUM_W-1:0]  r_prod, r_gap;
    logic [TIME_W-1:0] n_gap_peak;
    logic [SUM_W-1:0]  r_vol, r_val;
    logic [TIME_W-1:0] r_gpk;
    logic [WORD_W-1:0] r_ppk;
    logic              r_full;

    logic [AW-1:0]       w_idx;
    logic [TICKER_W-1:0] w_key_rd;
    logic [TIME_W-1:0]   w_prev_rd, w_gpk_rd;
    logic [SUM_W-1:0]    w_vol_rd, w_val_rd;
    logic [WORD_W-1:0]   w_ppk_rd;
    logic [TIME_W-1:0]   w_prev, w_gpk;
    logic [SUM_W-1:0]    w_vol, w_val;
    logic [WORD_W-1:0]   w_ppk;
    logic [SUM_W:0]      w_vol_add, w_val_add;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quo;
    logic                w_scan_last, w_match;
    logic [AW-1:0]       w_ram_raddr;
    logic                w_we;

    assign w_idx       = r_idx[AW-1:0];
    assign w_ram_raddr = i_cmd.scan ? w_idx : r_sel;

    // write back only when an entry was found or allocated
    assign w_we = i_cmd.wr && !r_full;

    // key memory; scanned one entry a cycle, read data registered
    tsst_ram #(.WIDTH(TICKER_W), .DEPTH(NUM_SYMBOLS)) u_key (
        .i_clk(i_clk), .i_we(w_we & r_new), .i_waddr(r_sel), .i_wdata(r_key),
        .i_raddr(w_ram_raddr), .o_rdata(w_key_rd)
    );
    tsst_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SYMBOLS)) u_prev (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_sel), .i_wdata(r_time),
        .i_raddr(r_sel), .o_rdata(w_prev_rd)
    );
    tsst_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SYMBOLS)) u_gpk (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_sel), .i_wdata(r_gpk),
        .i_raddr(r_sel), .o_rdata(w_gpk_rd)
    );
    tsst_ram #(.WIDTH(SUM_W), .DEPTH(NUM_SYMBOLS)) u_vol (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_sel), .i_wdata(r_vol),
        .i_raddr(r_sel), .o_rdata(w_vol_rd)
    );
    tsst_ram #(.WIDTH(SUM_W), .DEPTH(NUM_SYMBOLS)) u_val (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_sel), .i_wdata(r_val),
        .i_raddr(r_sel), .o_rdata(w_val_rd)
    );
    tsst_ram #(.WIDTH(WORD_W), .DEPTH(NUM_SYMBOLS)) u_ppk (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_sel), .i_wdata(r_ppk),
        .i_raddr(r_sel), .o_rdata(w_ppk_rd)
    );

    // r_idx counts issued reads; entry r_idx-1 is on the read port
    logic [AW-1:0] w_prev_idx;
    assign w_prev_idx  = AW'(r_idx - 1'b1);
    assign w_match     = (r_idx != '0) && r_used[w_prev_idx] && (w_key_rd == r_key);
    assign w_scan_last = i_cmd.scan && (r_hit || w_match || (r_idx == CW'(NUM_SYMBOLS)));
    assign o_stat.scan_last = w_scan_last;
    assign o_stat.div_done  = w_div_done;

    // fresh entries read as zero
    assign w_prev = r_new ? '0 : w_prev_rd;
    assign w_gpk  = r_new ? '0 : w_gpk_rd;
    assign w_vol  = r_new ? '0 : w_vol_rd;
    assign w_val  = r_new ? '0 : w_val_rd;
    assign w_ppk  = r_new ? '0 : w_ppk_rd;

    assign w_vol_add = {1'b0, w_vol} + {{(SUM_W-WORD_W+1){1'b0}}, r_qty};
    assign w_val_add = {1'b0, w_val} + {1'b0, r_prod};
    assign n_gap_peak = (w_prev != '0 && r_gap > w_gpk) ? r_gap : w_gpk;

    // capture, scan and update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_we && r_new) begin
            r_used[r_sel] <= 1'b1;
        end
        if (i_cmd.load) begin
            r_time <= i_trade_time;
            r_key  <= i_ticker;
            r_qty  <= i_quantity;
            r_price <= i_price;
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_free_found <= 1'b0;
            r_free <= '0;
        end
        if (i_cmd.scan && !r_hit) begin
            if (r_idx != CW'(NUM_SYMBOLS)) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_match) begin
                r_hit <= 1'b1;
                r_sel <= w_prev_idx;
            end else if (r_idx != '0 && !r_used[w_prev_idx] && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free <= w_prev_idx;
            end
        end
        if (i_cmd.rd) begin
            r_new  <= !r_hit;
            r_full <= !r_hit && !r_free_found;
            if (!r_hit) begin
                r_sel <= r_free;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= {{WORD_W{1'b0}}, r_price} * {{WORD_W{1'b0}}, r_qty};
            r_gap  <= r_time - w_prev;
        end
        if (i_cmd.acc) begin
            r_gpk <= n_gap_peak;
            r_ppk <= (r_price > w_ppk) ? r_price : w_ppk;
            r_vol <= w_vol_add[SUM_W] ? '1 : w_vol_add[SUM_W-1:0];
            r_val <= w_val_add[SUM_W] ? '1 : w_val_add[SUM_W-1:0];
        end
    end

    // average price divider
    tsst_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_val), .i_den(r_vol), .o_done(w_div_done), .o_quo(w_quo)
    );

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.done;
        end
        if (i_cmd.done) begin
            o_ticker_out <= r_key;
            o_table_full <= r_full;
            if (r_full) begin
                o_largest_gap   <= '0;
                o_total_volume  <= '0;
                o_average_price <= '0;
                o_top_price     <= '0;
            end else begin
                o_largest_gap   <= r_gpk;
                o_total_volume  <= r_vol;
                o_average_price <= (r_vol == '0) ? '0 :
                                   (w_quo[SUM_W-1:WORD_W] != '0) ? '1 : w_quo[WORD_W-1:0];
                o_top_price     <= r_ppk;
            end
        end
    end

    // datapath checks
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && r_full) |-> (&r_used)) else $error("full with free entry");
    a_hit_is_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul && !r_new) |-> r_used[r_sel]) else $error("hit on unused entry");
    a_vol_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> (r_vol >= $past(w_vol))) else $error("volume shrank");

endmodule

`default_nettype wire
